// ----- sv/hdf_pkg.sv -----
// ----------------------------------------------------------------------------
// hdf_pkg: shared constants of the haptic detent force unit
// Fixed-point format, mode and register codes, serial unit widths.
// ----------------------------------------------------------------------------
`default_nettype none

package hdf_pkg;

  // Angle fraction bits (Q16.16)
  localparam int ANGLE_FRAC_BITS = 16;

  // 2*pi with 32 fraction bits, rounded to the angle format
  localparam longint TWO_PI_Q32 = 64'd26986075409;
  localparam logic [31:0] TWO_PI_ANG =
      32'((TWO_PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS));

  localparam logic [7:0] BORDER_STRENGTH = 8'd255;

  // Modes
  localparam logic [1:0] MODE_HIT    = 2'd0;
  localparam logic [1:0] MODE_OPEN   = 2'd1;
  localparam logic [1:0] MODE_BORDER = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_SNAP_COUNT = 3'd1;
  localparam logic [2:0] REG_STRENGTH   = 3'd2;
  localparam logic [2:0] REG_LOWER      = 3'd3;
  localparam logic [2:0] REG_UPPER      = 3'd4;
  localparam logic [2:0] REG_SCALE      = 3'd5;

  // Serial multiplier widths
  localparam int MUL_A_W = 41;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial divider widths
  localparam int DIV_N_W = 42;
  localparam int DIV_D_W = 34;
  localparam int DIV_C_W = $clog2(DIV_N_W);

endpackage

`default_nettype wire

// ----- sv/hdf_mul.sv -----
// ----------------------------------------------------------------------------
// hdf_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle, stops early once the remaining bits are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hdf_mul (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [hdf_pkg::MUL_A_W-1:0] a_i,
  input  wire logic [hdf_pkg::MUL_B_W-1:0] b_i,
  output logic                             done_o,
  output logic [hdf_pkg::MUL_P_W-1:0]      p_o
);

  logic                        busy_q;
  logic [hdf_pkg::MUL_P_W-1:0] mc_q;
  logic [hdf_pkg::MUL_B_W-1:0] mp_q;
  logic [hdf_pkg::MUL_P_W-1:0] acc_q;

  assign done_o = busy_q && (mp_q == '0);
  assign p_o    = acc_q;

  // Control: busy until the multiplier bits run out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  // Datapath: add shifted multiplicand per set bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mc_q  <= hdf_pkg::MUL_P_W'(a_i);
      mp_q  <= b_i;
      acc_q <= '0;
    end else if (busy_q && (mp_q != '0)) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= {mc_q[hdf_pkg::MUL_P_W-2:0], 1'b0};
      mp_q <= {1'b0, mp_q[hdf_pkg::MUL_B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

// ----- sv/hdf_div.sv -----
// ----------------------------------------------------------------------------
// hdf_div: restoring divider
// One quotient bit per cycle over the full numerator width.
// ----------------------------------------------------------------------------
`default_nettype none

module hdf_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [hdf_pkg::DIV_N_W-1:0] num_i,
  input  wire logic [hdf_pkg::DIV_D_W-1:0] den_i,
  output logic                             done_o,
  output logic [hdf_pkg::DIV_N_W-1:0]      q_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [hdf_pkg::DIV_C_W-1:0] cnt_q;
  logic [hdf_pkg::DIV_N_W-1:0] quo_q;
  logic [hdf_pkg::DIV_D_W-1:0] rem_q;
  logic [hdf_pkg::DIV_D_W-1:0] den_q;
  logic [hdf_pkg::DIV_D_W:0]   trial;
  logic                        take;

  // Shift in the next numerator bit and compare
  assign trial = {rem_q, quo_q[hdf_pkg::DIV_N_W-1]};
  assign take  = (trial >= {1'b0, den_q});

  assign done_o = done_q;
  assign q_o    = quo_q;

  // Control: fixed number of steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == hdf_pkg::DIV_C_W'(hdf_pkg::DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Datapath: remainder and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? hdf_pkg::DIV_D_W'(trial - {1'b0, den_q})
                    : trial[hdf_pkg::DIV_D_W-1:0];
      quo_q <= {quo_q[hdf_pkg::DIV_N_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

// ----- sv/haptic_detent_force_unit.sv -----
// ----------------------------------------------------------------------------
// haptic_detent_force_unit: force law of a haptic knob
// Turns shaft-angle samples into a saturated drive force and snap index.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a shaft angle and a new target in tdata, the command in
//   tuser. A target beat loads the hit target and gives no output beat; an
//   angle beat gives one output beat with force, snap index and update flag.
//   Registers are to be written over the cfg port only while the unit is idle; the unit does not enforce this.
// Operation:
//   One item at a time. Work runs through a bit-serial multiplier, which
//   stops after the top set multiplier bit, and a restoring divider. Hit
//   and border push run two multiplies: distance times strength, then
//   times strength_scale. Snap modes, when they compute a snap, add two
//   multiply/divide pairs first. A target beat is taken in the idle state.
// Reset:
//   Registers take their reset values, strength_scale is 1.0, the target and
//   the snap index are zero, no output beat is pending.
// Stall:
//   A finished result sits in the output register until taken; the next item
//   may be accepted meanwhile, and its own result waits until the register
//   frees.
// ----------------------------------------------------------------------------
`default_nettype none

module haptic_detent_force_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: angle[31:0], hit target[63:32]
  input  wire logic [63:0] s_axis_tdata,
  // tuser: cmd
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: force_res[31:0], snap_index[47:32], snap_updated[48], zero[55:49]
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_DIV1, ST_MUL2, ST_DIV2, ST_FMUL1, ST_FMUL2, ST_FIN
  } state_e;

  // Configuration registers
  logic [1:0]         mode_q;
  logic [7:0]         snap_cnt_q;
  logic [7:0]         strength_q;
  logic signed [31:0] lower_q;
  logic signed [31:0] upper_q;
  logic [31:0]        scale_q;

  // Work registers
  state_e             st_q;
  logic               go_q;
  logic signed [31:0] target_q;
  logic signed [31:0] ang_q;
  logic [32:0]        x_q;
  logic [7:0]         k_q;
  logic [31:0]        d_q;
  logic signed [31:0] base_q;
  logic               neg_q;
  logic [21:0]        idx_q;
  logic               dneg_q;
  logic [32:0]        dmag_q;
  logic [7:0]         str_q;
  logic               zf_q;
  logic               upd_q;
  logic signed [15:0] snap_q;

  // Output register
  logic               m_valid_q;
  logic [31:0]        o_force_q;
  logic [15:0]        o_snap_q;
  logic               o_upd_q;

  // Serial units
  logic                        mul_done;
  logic [hdf_pkg::MUL_P_W-1:0] mul_p;
  logic [hdf_pkg::MUL_A_W-1:0] mul_a;
  logic [hdf_pkg::MUL_B_W-1:0] mul_b;
  logic                        div_done;
  logic [hdf_pkg::DIV_N_W-1:0] div_q;
  logic [hdf_pkg::DIV_N_W-1:0] div_num;
  logic [hdf_pkg::DIV_D_W-1:0] div_den;

  // Input fields
  logic               s_fire;
  logic signed [31:0] in_ang;
  logic signed [31:0] in_tgt;
  logic signed [35:0] d_hit;
  logic signed [35:0] d_lb;
  logic signed [35:0] d_ub;

  // Snap results
  logic [hdf_pkg::DIV_N_W-1:0] idx_cl;
  logic signed [15:0]          snap_sat;
  logic signed [35:0]          tgt_snap;
  logic signed [35:0]          d_snap;

  // Force saturation
  logic [56:0] f_mag;
  logic [56:0] f_lim;
  logic [31:0] f_sat;

  function automatic logic [32:0] mag33(input logic signed [35:0] v);
    logic [35:0] m;
    m = v[35] ? 36'(-v) : 36'(v);
    return m[32:0];
  endfunction

  assign s_axis_tready = (st_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_ang        = s_axis_tdata[31:0];
  assign in_tgt        = s_axis_tdata[63:32];

  // Differences toward target and borders
  assign d_hit = 36'(target_q) - 36'(in_ang);
  assign d_lb  = 36'(lower_q) - 36'(in_ang);
  assign d_ub  = 36'(upper_q) - 36'(in_ang);

  // Clamp the border index and saturate the snap index
  always_comb begin
    idx_cl = div_q;
    if ((mode_q == hdf_pkg::MODE_BORDER) && (div_q > hdf_pkg::DIV_N_W'(k_q))) begin
      idx_cl = hdf_pkg::DIV_N_W'(k_q);
    end
    if (neg_q) begin
      snap_sat = (idx_cl >= hdf_pkg::DIV_N_W'(32768)) ? 16'sh8000
                                                      : 16'(-idx_cl[15:0]);
    end else begin
      snap_sat = (idx_cl > hdf_pkg::DIV_N_W'(32767)) ? 16'sh7fff : 16'(idx_cl[15:0]);
    end
  end

  // Snap target and its distance
  assign tgt_snap = 36'(base_q) + (neg_q ? -36'(div_q[33:0]) : 36'(div_q[33:0]));
  assign d_snap   = tgt_snap - 36'(ang_q);

  // Saturate the force magnitude
  assign f_mag = mul_p[hdf_pkg::MUL_P_W-1:hdf_pkg::ANGLE_FRAC_BITS];
  assign f_lim = dneg_q ? 57'h80000000 : 57'h7fffffff;
  always_comb begin
    f_sat = (f_mag > f_lim) ? f_lim[31:0] : f_mag[31:0];
    if (dneg_q) begin
      f_sat = -f_sat;
    end
  end

  // Route operands to the serial units
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_num = '0;
    div_den = '0;
    case (st_q)
      ST_MUL1: begin
        mul_a = hdf_pkg::MUL_A_W'(x_q);
        mul_b = hdf_pkg::MUL_B_W'(k_q);
      end
      ST_DIV1: begin
        div_num = {mul_p[hdf_pkg::DIV_N_W-2:0], 1'b0} + hdf_pkg::DIV_N_W'(d_q);
        div_den = {1'b0, d_q, 1'b0};
      end
      ST_MUL2: begin
        mul_a = hdf_pkg::MUL_A_W'(idx_q);
        mul_b = d_q;
      end
      ST_DIV2: begin
        div_num = {mul_p[hdf_pkg::DIV_N_W-2:0], 1'b0} + hdf_pkg::DIV_N_W'(k_q);
        div_den = hdf_pkg::DIV_D_W'({k_q, 1'b0});
      end
      ST_FMUL1: begin
        mul_a = hdf_pkg::MUL_A_W'(dmag_q);
        mul_b = hdf_pkg::MUL_B_W'(str_q);
      end
      ST_FMUL2: begin
        mul_a = mul_p[hdf_pkg::MUL_A_W-1:0];
        mul_b = scale_q;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  hdf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && (st_q == ST_MUL1 || st_q == ST_MUL2 ||
                       st_q == ST_FMUL1 || st_q == ST_FMUL2)),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  hdf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && (st_q == ST_DIV1 || st_q == ST_DIV2)),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= hdf_pkg::MODE_HIT;
      snap_cnt_q <= '0;
      strength_q <= '0;
      lower_q    <= '0;
      upper_q    <= '0;
      scale_q    <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hdf_pkg::REG_MODE:       mode_q     <= cfg_data_i[1:0];
        hdf_pkg::REG_SNAP_COUNT: snap_cnt_q <= cfg_data_i[7:0];
        hdf_pkg::REG_STRENGTH:   strength_q <= cfg_data_i[7:0];
        hdf_pkg::REG_LOWER:      lower_q    <= cfg_data_i;
        hdf_pkg::REG_UPPER:      upper_q    <= cfg_data_i;
        hdf_pkg::REG_SCALE:      scale_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sequence one item and hold the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      go_q      <= 1'b0;
      target_q  <= '0;
      snap_q    <= '0;
      m_valid_q <= 1'b0;
      ang_q     <= '0;
      x_q       <= '0;
      k_q       <= '0;
      d_q       <= '0;
      base_q    <= '0;
      neg_q     <= 1'b0;
      idx_q     <= '0;
      dneg_q    <= 1'b0;
      dmag_q    <= '0;
      str_q     <= '0;
      zf_q      <= 1'b0;
      upd_q     <= 1'b0;
      o_force_q <= '0;
      o_snap_q  <= '0;
      o_upd_q   <= 1'b0;
    end else begin
      go_q <= 1'b0;
      // Drop the output beat once taken, unless a new one replaces it
      if (m_valid_q && m_axis_tready && (st_q != ST_FIN)) begin
        m_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE: begin
          if (s_fire) begin
            if (s_axis_tuser) begin
              target_q <= in_tgt;
            end else begin
              ang_q <= in_ang;
              zf_q  <= 1'b0;
              upd_q <= 1'b0;
              str_q <= strength_q;
              case (mode_q)
                hdf_pkg::MODE_HIT: begin
                  dneg_q <= d_hit[35];
                  dmag_q <= mag33(d_hit);
                  st_q   <= ST_FMUL1;
                  go_q   <= 1'b1;
                end
                hdf_pkg::MODE_OPEN: begin
                  if (snap_cnt_q == '0) begin
                    zf_q <= 1'b1;
                    st_q <= ST_FIN;
                  end else begin
                    x_q    <= mag33(36'(in_ang));
                    k_q    <= snap_cnt_q;
                    d_q    <= hdf_pkg::TWO_PI_ANG;
                    base_q <= '0;
                    neg_q  <= in_ang[31];
                    st_q   <= ST_MUL1;
                    go_q   <= 1'b1;
                  end
                end
                hdf_pkg::MODE_BORDER: begin
                  if (in_ang < lower_q) begin
                    dneg_q <= d_lb[35];
                    dmag_q <= mag33(d_lb);
                    str_q  <= hdf_pkg::BORDER_STRENGTH;
                    st_q   <= ST_FMUL1;
                    go_q   <= 1'b1;
                  end else if (in_ang > upper_q) begin
                    dneg_q <= d_ub[35];
                    dmag_q <= mag33(d_ub);
                    str_q  <= hdf_pkg::BORDER_STRENGTH;
                    st_q   <= ST_FMUL1;
                    go_q   <= 1'b1;
                  end else if (snap_cnt_q == '0) begin
                    zf_q <= 1'b1;
                    st_q <= ST_FIN;
                  end else if ((snap_cnt_q == 8'd1) || (lower_q == upper_q)) begin
                    // single point: snap straight to the lower border
                    snap_q <= '0;
                    upd_q  <= 1'b1;
                    dneg_q <= d_lb[35];
                    dmag_q <= mag33(d_lb);
                    st_q   <= ST_FMUL1;
                    go_q   <= 1'b1;
                  end else begin
                    x_q    <= 33'(-d_lb);
                    k_q    <= snap_cnt_q - 8'd1;
                    d_q    <= 32'(upper_q - lower_q);
                    base_q <= lower_q;
                    neg_q  <= 1'b0;
                    st_q   <= ST_MUL1;
                    go_q   <= 1'b1;
                  end
                end
                default: begin
                  zf_q <= 1'b1;
                  st_q <= ST_FIN;
                end
              endcase
            end
          end
        end
        ST_MUL1: begin
          if (mul_done) begin
            st_q <= ST_DIV1;
            go_q <= 1'b1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            idx_q  <= idx_cl[21:0];
            snap_q <= snap_sat;
            upd_q  <= 1'b1;
            st_q   <= ST_MUL2;
            go_q   <= 1'b1;
          end
        end
        ST_MUL2: begin
          if (mul_done) begin
            st_q <= ST_DIV2;
            go_q <= 1'b1;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            dneg_q <= d_snap[35];
            dmag_q <= mag33(d_snap);
            st_q   <= ST_FMUL1;
            go_q   <= 1'b1;
          end
        end
        ST_FMUL1: begin
          if (mul_done) begin
            st_q <= ST_FMUL2;
            go_q <= 1'b1;
          end
        end
        ST_FMUL2: begin
          if (mul_done) begin
            st_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            o_force_q <= zf_q ? 32'd0 : f_sat;
            o_snap_q  <= snap_q;
            o_upd_q   <= upd_q;
            st_q      <= ST_IDLE;
          end
        end
        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, o_upd_q, o_snap_q, o_force_q};

  // A result appears only out of the final state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(st_q == ST_FIN))
    else $error("output beat raised outside the final state");

  // A snap update only comes from a snap mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN && upd_q) |->
      (mode_q == hdf_pkg::MODE_OPEN || mode_q == hdf_pkg::MODE_BORDER))
    else $error("snap update in a mode without snaps");

  // The border index stays within the snap range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MUL2 && mode_q == hdf_pkg::MODE_BORDER) |-> (idx_q <= 22'(k_q)))
    else $error("border snap index beyond the last point");

  // No new item while one is at work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input accepted while busy");

endmodule

`default_nettype wire
